>>> sv/kmp_stream_matcher_top_assert.svh
// Assertion macros shared by the matcher RTL.
`ifndef KMP_STREAM_MATCHER_TOP_ASSERT_SVH
`define KMP_STREAM_MATCHER_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define KMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kmp_pkg.sv
`timescale 1ns / 1ps

package kmp_pkg;

    // Default pattern capacity and symbol width
    localparam int KMP_MAX_PATTERN = 64;
    localparam int KMP_SYMBOL_BITS = 8;

    // Request kinds carried by req_type
    typedef enum logic [0:0] {
        REQ_PATTERN = 1'b0,
        REQ_TEXT    = 1'b1
    } req_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHASE
    } state_t;

endpackage

>>> sv/kmp_in_if.sv
`timescale 1ns / 1ps

interface kmp_in_if #(
    parameter int SYMBOL_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   start_req;

    modport source (output valid, output req_type, output symbol, output start_req,
                    input ready);
    modport sink   (input valid, input req_type, input symbol, input start_req,
                    output ready);
endinterface

>>> sv/kmp_out_if.sv
`timescale 1ns / 1ps

interface kmp_out_if #(
    parameter int INDEX_BITS = 7
);
    logic                         valid;
    logic                         ready;
    logic signed [INDEX_BITS-1:0] matched_index;
    logic                         full_match;

    modport source (output valid, output matched_index, output full_match, input ready);
    modport sink   (input valid, input matched_index, input full_match, output ready);
endinterface

>>> sv/kmp_stream_matcher_top.sv
`timescale 1ns / 1ps
//  channel | dir | transaction payload                  | result
//  in_ch   | in  | req_type, symbol, start_req          | none for pattern, one for text
//  out_ch  | out | matched_index (signed), full_match   | one per text symbol
//
//  Text symbol: accepted in IDLE, then CHASE follows fallback links until a hit or -1.
//  Pattern symbol: adds a FETCH of the prior fallback entry first; a dropped one, only the accept.
//  The pace is set by the single read port shared by the symbol and fallback memories:
//  one link per cycle. Amortized at most one link per symbol.
//  Reset clears length and match position at once; no clearing pass, fallback entry
//  zero reads as -1 by decode. A waiting result stalls only the next text chase end.

module kmp_stream_matcher_top
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = KMP_MAX_PATTERN,
    parameter int SYMBOL_BITS = KMP_SYMBOL_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    kmp_in_if.sink    in_ch,
    kmp_out_if.source out_ch
);

    `include "kmp_stream_matcher_top_assert.svh"

    // Address and index widths
    localparam int AW  = $clog2(MAX_PATTERN + 1);
    localparam int PAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int IW  = AW + 1;
    localparam int OW  = $clog2(MAX_PATTERN) + 1;

    // Memories
    logic [SYMBOL_BITS-1:0] ps_mem [MAX_PATTERN];
    logic signed [IW-1:0]   fb_mem [MAX_PATTERN + 1];
    logic [SYMBOL_BITS-1:0] ps_rd_reg;
    logic signed [IW-1:0]   fb_rd_reg;
    logic                   rd_zero_reg;

    // Control and datapath registers
    state_t                 state_reg, state_next;
    req_t                   kind_reg, kind_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic signed [IW-1:0]   j_reg, j_next;
    logic [AW-1:0]          bound_reg, bound_next;
    logic [AW-1:0]          len_reg, len_next;
    logic [AW-1:0]          mp_reg, mp_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [OW-1:0]   out_idx_reg, out_idx_next;
    logic                   out_full_reg, out_full_next;

    // Combinational helpers
    logic                   accept;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   ps_we;
    logic [PAW-1:0]         ps_waddr;
    logic                   fb_we;
    logic [AW-1:0]          fb_waddr;
    logic signed [IW-1:0]   fb_eff;
    logic signed [IW-1:0]   j_plus1;
    logic signed [IW-1:0]   len_m1;
    logic [AW-1:0]          len_eff;
    logic [AW-1:0]          text_j;
    logic                   j_neg;
    logic                   hit;
    logic                   done;
    logic                   out_free;
    logic                   finish;

    assign accept   = in_ch.valid && in_ch.ready;
    assign fb_eff   = rd_zero_reg ? {IW{1'b1}} : fb_rd_reg;
    assign j_plus1  = j_reg + IW'(1);
    assign len_m1   = $signed({1'b0, bound_reg}) - IW'(1);
    assign len_eff  = in_ch.start_req ? '0 : len_reg;
    assign text_j   = in_ch.start_req ? '0 : mp_reg;
    assign j_neg    = j_reg[IW-1];
    assign hit      = !j_neg && (j_reg[AW-1:0] < bound_reg) && (ps_rd_reg == sym_reg);
    assign done     = j_neg || hit;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign finish   = (state_reg == ST_CHASE) && done
                      && ((kind_reg == REQ_PATTERN) || out_free);
    assign ps_waddr = len_eff[PAW-1:0];
    assign fb_waddr = bound_reg + AW'(1);

    // Drive ports
    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.matched_index = out_idx_reg;
    assign out_ch.full_match    = out_full_reg;

    // Symbol memory: write on pattern append, read at the chase address
    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= in_ch.symbol;
        end
        if (rd_en)
        begin
            ps_rd_reg <= ps_mem[rd_addr[PAW-1:0]];
        end
    end

    // Fallback memory: write the new entry at pattern end, read alongside symbols
    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_mem[fb_waddr] <= j_plus1;
        end
        if (rd_en)
        begin
            fb_rd_reg   <= fb_mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.req_type == REQ_TEXT)
                    begin
                        state_next = ST_CHASE;
                    end
                    else if (len_eff != AW'(MAX_PATTERN))
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHASE;
            end
            ST_CHASE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result loading
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = j_reg[AW-1:0];
        ps_we          = 1'b0;
        fb_we          = 1'b0;
        kind_next      = kind_reg;
        sym_next       = sym_reg;
        j_next         = j_reg;
        bound_next     = bound_reg;
        len_next       = len_reg;
        mp_next        = mp_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_idx_next   = out_idx_reg;
        out_full_next  = out_full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next  = in_ch.symbol;
                    kind_next = req_t'(in_ch.req_type);
                    if (in_ch.req_type == REQ_TEXT)
                    begin
                        // Start the chase at the current match position
                        j_next     = $signed({1'b0, text_j});
                        bound_next = len_reg;
                        rd_en      = 1'b1;
                        rd_addr    = text_j;
                    end
                    else
                    begin
                        mp_next = '0;
                        if (len_eff == AW'(MAX_PATTERN))
                        begin
                            // Drop: pattern full
                            len_next = len_eff;
                        end
                        else
                        begin
                            // Store symbol, fetch fallback of the old length
                            ps_we      = 1'b1;
                            bound_next = len_eff;
                            rd_en      = 1'b1;
                            rd_addr    = len_eff;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                j_next  = fb_eff;
                rd_en   = !fb_eff[IW-1];
                rd_addr = fb_eff[AW-1:0];
            end
            ST_CHASE:
            begin
                if (!done)
                begin
                    // Follow one fallback link
                    j_next  = fb_eff;
                    rd_en   = !fb_eff[IW-1];
                    rd_addr = fb_eff[AW-1:0];
                end
                else if (finish)
                begin
                    if (kind_reg == REQ_PATTERN)
                    begin
                        fb_we    = 1'b1;
                        len_next = bound_reg + AW'(1);
                    end
                    else
                    begin
                        mp_next        = j_plus1[AW-1:0];
                        out_valid_next = 1'b1;
                        out_idx_next   = j_reg[OW-1:0];
                        out_full_next  = !j_neg && (j_reg == len_m1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            mp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            mp_reg        <= mp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sym_reg      <= sym_next;
        j_reg        <= j_next;
        bound_reg    <= bound_next;
        out_idx_reg  <= out_idx_next;
        out_full_reg <= out_full_next;
    end

    // Checks
    `KMP_ASSERT_SAME(a_mp_in_range, 1'b1, mp_reg <= len_reg,
        "match position beyond pattern length")
    `KMP_ASSERT_SAME(a_len_in_range, 1'b1, len_reg <= AW'(MAX_PATTERN),
        "pattern length beyond capacity")
    `KMP_ASSERT_SAME(a_chase_bound, (state_reg == ST_CHASE) && !j_neg,
        j_reg[AW-1:0] <= bound_reg, "chase index beyond bound")
    `KMP_ASSERT_SAME(a_result_from_text, $rose(out_valid_reg),
        $past(state_reg == ST_CHASE && kind_reg == REQ_TEXT),
        "result raised without a text chase")

endmodule

>>> sim/tb_kmp_stream_matcher_top.sv
`timescale 1ns / 1ps

module tb_kmp_stream_matcher_top;
    import kmp_pkg::*;

    localparam int PAT_CAP       = KMP_MAX_PATTERN;
    localparam int SYM_W         = KMP_SYMBOL_BITS;
    localparam int SYM_MAX       = (1 << SYM_W) - 1;
    localparam int IDX_W         = 7;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLDOFF_LEN   = 400;

    typedef struct packed {
        logic signed [IDX_W-1:0] idx;
        logic                    full;
    } match_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY_THIRD
    } rx_mode_t;

    logic clk;
    logic rst_n;

    kmp_in_if  #(.SYMBOL_BITS(SYM_W)) in_ch ();
    kmp_out_if #(.INDEX_BITS(IDX_W))  out_ch ();

    kmp_stream_matcher_top #(
        .MAX_PATTERN(PAT_CAP),
        .SYMBOL_BITS(SYM_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Matcher state mirror: pattern symbols, failure links, length, position
    logic [SYM_W-1:0] pat_mem [PAT_CAP];
    int               fail_link [PAT_CAP+1];
    int               pat_len   = 0;
    int               match_pos = 0;
    match_t           expected_matches [$];

    int error_count  = 0;
    int n_pattern    = 0;
    int n_dropped    = 0;
    int n_text       = 0;
    int n_results    = 0;
    int n_full_seen  = 0;

    // Sender and receiver pacing
    int       burst_left   = 0;
    bit       gapless      = 1'b0;
    int       holdoff_left = 0;
    int       rx_phase     = 0;
    rx_mode_t rx_mode      = RX_ALWAYS;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still pending", expected_matches.size());
        $display("simulation failed");
        $finish;
    end

    function automatic logic [SYM_W-1:0] rand_sym();
        return SYM_W'($urandom_range(0, SYM_MAX));
    endfunction

    // Walk failure links until the stored symbol equals sym or the index drops to -1
    function automatic int follow_links(int from, logic [SYM_W-1:0] sym, int len);
        int  j;
        int  guard;
        bit  hit;
        j     = from;
        guard = 0;
        hit   = 1'b0;
        while (!hit && j >= 0 && j <= len && guard <= PAT_CAP + 1)
        begin
            if (j < len && pat_mem[j] == sym)
                hit = 1'b1;
            else
            begin
                j = fail_link[j];
                guard++;
            end
        end
        if (j > len)
            j = -1;
        return j;
    endfunction

    // Update the mirror for one accepted transaction and queue its match result
    function automatic void predict_transaction(req_t kind, logic [SYM_W-1:0] sym, bit start);
        int     j;
        match_t res;
        if (kind == REQ_PATTERN)
        begin
            n_pattern++;
            if (start)
                pat_len = 0;
            match_pos = 0;
            if (pat_len < PAT_CAP)
            begin
                pat_mem[pat_len] = sym;
                j = follow_links(fail_link[pat_len], sym, pat_len);
                fail_link[pat_len + 1] = j + 1;
                pat_len++;
            end
            else
                n_dropped++;
        end
        else
        begin
            n_text++;
            if (start)
                match_pos = 0;
            j = follow_links(match_pos, sym, pat_len);
            match_pos = j + 1;
            res.idx  = j[IDX_W-1:0];
            res.full = (j >= 0 && j == pat_len - 1);
            expected_matches.push_back(res);
        end
    endfunction

    // Offer one transaction, with a random gap between bursts, and wait for acceptance
    task automatic send_item(req_t kind, logic [SYM_W-1:0] sym, bit start);
        int gap;
        if (!gapless && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= kind;
        in_ch.symbol    <= sym;
        in_ch.start_req <= start;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        predict_transaction(kind, sym, start);
    endtask

    // Stop offering and wait until every queued result has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_matches.size() != 0);
    endtask

    // Receiver: long hold-off on request, otherwise a stall pattern that changes mode
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_left > 0)
            begin
                out_ch.ready <= 1'b0;
                holdoff_left--;
            end
            else
            begin
                rx_phase++;
                if (rx_phase >= 48)
                begin
                    rx_phase = 0;
                    rx_mode  = rx_mode_t'($urandom_range(0, 3));
                end
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_COIN:    out_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ch.ready <= (rx_phase % 3 == 0);
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest queued match result
    always @(posedge clk)
    begin : check_results
        match_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (out_ch.full_match === 1'b1)
                n_full_seen++;
            if (expected_matches.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result index=%0d full=%b", $realtime,
                             out_ch.matched_index, out_ch.full_match);
            end
            else
            begin
                want = expected_matches.pop_front();
                if (out_ch.matched_index !== want.idx || out_ch.full_match !== want.full)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result %0d index exp=%0d got=%0d, full exp=%b got=%b",
                                 $realtime, n_results, want.idx, out_ch.matched_index,
                                 want.full, out_ch.full_match);
                end
            end
        end
    end

    // Text against an empty pattern never matches
    task automatic test_empty_pattern();
        send_item(REQ_TEXT, '0, 1'b1);
        send_item(REQ_TEXT, '1, 1'b0);
        send_item(REQ_TEXT, 8'h5A, 1'b1);
    endtask

    // Overlapping occurrences, then a mismatch that falls back to -1
    task automatic test_overlapping_matches();
        send_item(REQ_PATTERN, '0, 1'b1);
        send_item(REQ_PATTERN, '1, 1'b0);
        send_item(REQ_PATTERN, '0, 1'b0);
        send_item(REQ_TEXT, '0, 1'b1);
        send_item(REQ_TEXT, '1, 1'b0);
        send_item(REQ_TEXT, '0, 1'b0);
        send_item(REQ_TEXT, '1, 1'b0);
        send_item(REQ_TEXT, '0, 1'b0);
        send_item(REQ_TEXT, 8'h7E, 1'b0);
    endtask

    // Append mid-text, new text, and a new single-symbol pattern
    task automatic test_restarts();
        send_item(REQ_PATTERN, '1, 1'b0);
        send_item(REQ_TEXT, '0, 1'b0);
        send_item(REQ_TEXT, '1, 1'b0);
        send_item(REQ_TEXT, '0, 1'b0);
        send_item(REQ_TEXT, '1, 1'b0);
        send_item(REQ_TEXT, '0, 1'b1);
        send_item(REQ_PATTERN, 8'h80, 1'b1);
        send_item(REQ_TEXT, 8'h80, 1'b0);
        send_item(REQ_TEXT, 8'h01, 1'b1);
    endtask

    // Fill the pattern to capacity, drop extra symbols, match full-length copies
    task automatic test_capacity();
        logic [SYM_W-1:0] pair [2];
        logic [SYM_W-1:0] pat [PAT_CAP];
        int               k;
        pair[0] = rand_sym();
        pair[1] = rand_sym();
        for (k = 0; k < PAT_CAP; k++)
        begin
            pat[k] = pair[$urandom_range(0, 1)];
            send_item(REQ_PATTERN, pat[k], k == 0);
        end
        send_item(REQ_PATTERN, rand_sym(), 1'b0);
        send_item(REQ_PATTERN, rand_sym(), 1'b0);
        for (k = 0; k < 2 * PAT_CAP; k++)
            send_item(REQ_TEXT, pat[k % PAT_CAP], k == 0);
        for (k = 0; k < 12; k++)
            send_item(REQ_TEXT, pair[$urandom_range(0, 1)], 1'b0);
        send_item(REQ_PATTERN, rand_sym(), 1'b0);
        for (k = 0; k < PAT_CAP + 4; k++)
            send_item(REQ_TEXT, (k < PAT_CAP) ? pat[k] : pair[$urandom_range(0, 1)], 1'b0);
    endtask

    // Mostly well-formed pattern/text sequences over a small alphabet, some noise
    task automatic test_random_sequences(int budget);
        logic [SYM_W-1:0] alpha [3];
        logic [SYM_W-1:0] pat [$];
        int               sent;
        int               plen;
        int               tlen;
        int               asize;
        int               k;
        int               n;
        bit               fresh;
        sent = 0;
        while (sent < budget)
        begin
            gapless = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                asize = $urandom_range(1, 3);
                foreach (alpha[i])
                    alpha[i] = rand_sym();
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                pat.delete();
                for (k = 0; k < plen; k++)
                begin
                    pat.push_back(alpha[$urandom_range(0, asize - 1)]);
                    send_item(REQ_PATTERN, pat[k], k == 0);
                end
                fresh = ($urandom_range(0, 9) != 0);
                tlen  = $urandom_range(plen, 3 * plen + 10);
                k     = 0;
                while (k < tlen)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        foreach (pat[m])
                        begin
                            send_item(REQ_TEXT, pat[m], fresh && k == 0);
                            k++;
                        end
                    end
                    else
                    begin
                        send_item(REQ_TEXT, alpha[$urandom_range(0, asize - 1)], fresh && k == 0);
                        k++;
                    end
                end
                sent += plen + k;
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_item(req_t'($urandom_range(0, 1)), rand_sym(),
                              $urandom_range(0, 3) == 0);
                sent += n;
            end
        end
        gapless = 1'b0;
    endtask

    // Hold the receiver off while text keeps coming, so the input stalls
    task automatic test_backpressure();
        int k;
        wait_drained();
        send_item(REQ_PATTERN, 8'h33, 1'b1);
        send_item(REQ_PATTERN, 8'h33, 1'b0);
        gapless      = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        for (k = 0; k < 48; k++)
            send_item(REQ_TEXT, ($urandom_range(0, 5) == 0) ? 8'h34 : 8'h33, k == 0);
        gapless = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_PATTERN;
        in_ch.symbol    = '0;
        in_ch.start_req = 1'b0;
        foreach (pat_mem[i])
            pat_mem[i] = '0;
        foreach (fail_link[i])
            fail_link[i] = 0;
        fail_link[0] = -1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_overlapping_matches();
        test_restarts();
        test_capacity();
        test_random_sequences(650);
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pattern symbols (%0d dropped when full) and %0d text symbols",
                 n_pattern, n_dropped, n_text);
        $display("Checked %0d match results, %0d of them full matches, %0d mismatches",
                 n_results, n_full_seen, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
